@@ hdl/itoa_pkg.sv @@
// Shared types, constants and character helpers for the integer-to-ASCII formatter.
package itoa_pkg;

  localparam int unsigned DEC_BITS   = 32;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_BITS   = 32;
  localparam int unsigned NIL_LEN    = 5;
  localparam int unsigned CNT_W      = 5;

  typedef enum logic [1:0] {
    FMT_DEC  = 2'd0,
    FMT_HEXL = 2'd1,
    FMT_HEXU = 2'd2,
    FMT_PTR  = 2'd3
  } fmt_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_PFX0,
    ST_PFX1,
    ST_DIGIT,
    ST_NIL
  } state_e;

  typedef enum logic [1:0] {
    SEL_DIGIT,
    SEL_ZERO,
    SEL_X,
    SEL_NIL
  } char_sel_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0]       char_code;
    logic             last_char;
    logic [CNT_W-1:0] char_count;
  } res_t;

  typedef struct packed {
    logic      load;
    logic      dd_step;
    logic      size;
    logic      emit;
    logic      last;
    char_sel_e sel;
  } ctrl_t;

  typedef struct packed {
    fmt_e fmt;
    logic dd_done;
    logic ptr_zero;
    logic dig_last;
    logic nil_last;
  } stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else if (upper) begin
      c = 8'h41 + {4'd0, nib} - 8'd10;
    end else begin
      c = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6c;
      3'd4:    c = 8'h29;
      default: c = 8'h3f;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/itoa_ctrl.sv @@
// Sequencing state machine: load, binary-to-BCD conversion, sizing and character emission.
module itoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  itoa_pkg::fmt_e      fmt_i,
  input  itoa_pkg::stat_t     stat_i,
  output itoa_pkg::ctrl_t     cmd_o,
  output logic                busy
);

  itoa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (fmt_i == itoa_pkg::FMT_DEC) ? itoa_pkg::ST_CONV : itoa_pkg::ST_SIZE;
        end
      end
      itoa_pkg::ST_CONV: begin
        if (stat_i.dd_done) begin
          state_d = itoa_pkg::ST_SIZE;
        end
      end
      itoa_pkg::ST_SIZE: begin
        if (stat_i.fmt != itoa_pkg::FMT_PTR) begin
          state_d = itoa_pkg::ST_DIGIT;
        end else if (stat_i.ptr_zero) begin
          state_d = itoa_pkg::ST_NIL;
        end else begin
          state_d = itoa_pkg::ST_PFX0;
        end
      end
      itoa_pkg::ST_PFX0: state_d = itoa_pkg::ST_PFX1;
      itoa_pkg::ST_PFX1: state_d = itoa_pkg::ST_DIGIT;
      itoa_pkg::ST_DIGIT: begin
        if (stat_i.dig_last) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      itoa_pkg::ST_NIL: begin
        if (stat_i.nil_last) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{load: 1'b0, dd_step: 1'b0, size: 1'b0, emit: 1'b0, last: 1'b0,
              sel: itoa_pkg::SEL_DIGIT};
    busy  = 1'b1;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      itoa_pkg::ST_CONV: cmd_o.dd_step = 1'b1;
      itoa_pkg::ST_SIZE: cmd_o.size = 1'b1;
      itoa_pkg::ST_PFX0: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = itoa_pkg::SEL_ZERO;
      end
      itoa_pkg::ST_PFX1: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = itoa_pkg::SEL_X;
      end
      itoa_pkg::ST_DIGIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = itoa_pkg::SEL_DIGIT;
        cmd_o.last = stat_i.dig_last;
      end
      itoa_pkg::ST_NIL: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = itoa_pkg::SEL_NIL;
        cmd_o.last = stat_i.nil_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ hdl/itoa_dp.sv @@
// Datapath: digit register with double-dabble step, digit sizing, character select, output beat.
module itoa_dp #(
  parameter int unsigned POINTER_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  itoa_pkg::req_t  req_i,
  input  itoa_pkg::ctrl_t cmd_i,
  output itoa_pkg::stat_t stat_o,
  output itoa_pkg::res_t  res_o,
  output logic            res_valid_o
);

  localparam int unsigned PTR_NIB = (POINTER_BITS + 3) / 4;
  localparam int unsigned NIB     = (PTR_NIB > itoa_pkg::DEC_DIGITS) ?
                                    PTR_NIB : itoa_pkg::DEC_DIGITS;
  localparam int unsigned DW      = NIB * 4;
  localparam int unsigned IDX_W   = $clog2(NIB);
  localparam int unsigned ND_W    = $clog2(NIB + 1);
  localparam int unsigned DD_W    = $clog2(itoa_pkg::DEC_BITS);

  itoa_pkg::fmt_e                fmt_q;
  logic                          ptr_zero_q;
  logic [itoa_pkg::DEC_BITS-1:0] bin_q;
  logic [DD_W-1:0]               dd_cnt_q;
  logic [NIB-1:0][3:0]           digs_q, digs_d;
  logic [NIB-1:0][3:0]           corr;
  logic [ND_W-1:0]               ndig_q, ndig_calc;
  logic [itoa_pkg::CNT_W-1:0]    cnt_q;
  itoa_pkg::res_t                res_q, res_d;
  logic                          valid_q;
  logic [IDX_W-1:0]              dig_idx;
  logic [7:0]                    ch;

  // add-3 correction on every BCD nibble
  always_comb begin
    for (int i = 0; i < NIB; i++) begin
      corr[i] = (digs_q[i] >= 4'd5) ? digs_q[i] + 4'd3 : digs_q[i];
    end
  end

  always_comb begin
    ndig_calc = ND_W'(1);
    for (int i = 0; i < NIB; i++) begin
      if (digs_q[i] != 4'd0) begin
        ndig_calc = ND_W'(i + 1);
      end
    end
  end

  always_comb begin
    digs_d = digs_q;
    if (cmd_i.load) begin
      case (itoa_pkg::fmt_e'(req_i.req_type))
        itoa_pkg::FMT_DEC: digs_d = '0;
        itoa_pkg::FMT_PTR: digs_d = DW'(req_i.value[POINTER_BITS-1:0]);
        default:           digs_d = DW'(req_i.value[itoa_pkg::HEX_BITS-1:0]);
      endcase
    end else if (cmd_i.dd_step) begin
      digs_d = {DW'(corr) << 1} | DW'(bin_q[itoa_pkg::DEC_BITS-1]);
    end
  end

  assign dig_idx = IDX_W'(ndig_q - ND_W'(1));

  always_comb begin
    case (cmd_i.sel)
      itoa_pkg::SEL_ZERO: ch = 8'h30;
      itoa_pkg::SEL_X:    ch = 8'h78;
      itoa_pkg::SEL_NIL:  ch = itoa_pkg::nil_char(cnt_q[2:0]);
      default:            ch = itoa_pkg::hex_char(digs_q[dig_idx], fmt_q == itoa_pkg::FMT_HEXU);
    endcase
    res_d.char_code  = ch;
    res_d.last_char  = cmd_i.last;
    res_d.char_count = cnt_q + itoa_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q <= digs_d;
    if (cmd_i.load) begin
      fmt_q      <= itoa_pkg::fmt_e'(req_i.req_type);
      ptr_zero_q <= (req_i.value[POINTER_BITS-1:0] == '0);
      bin_q      <= req_i.value[itoa_pkg::DEC_BITS-1:0];
      dd_cnt_q   <= '0;
      cnt_q      <= '0;
    end
    if (cmd_i.dd_step) begin
      bin_q    <= bin_q << 1;
      dd_cnt_q <= dd_cnt_q + DD_W'(1);
    end
    if (cmd_i.size) begin
      ndig_q <= ndig_calc;
    end
    if (cmd_i.emit) begin
      cnt_q <= cnt_q + itoa_pkg::CNT_W'(1);
      res_q <= res_d;
      if (cmd_i.sel == itoa_pkg::SEL_DIGIT) begin
        ndig_q <= ndig_q - ND_W'(1);
      end
    end
  end

  assign stat_o.fmt      = fmt_q;
  assign stat_o.dd_done  = (dd_cnt_q == DD_W'(itoa_pkg::DEC_BITS - 1));
  assign stat_o.ptr_zero = ptr_zero_q;
  assign stat_o.dig_last = (ndig_q == ND_W'(1));
  assign stat_o.nil_last = (cnt_q == itoa_pkg::CNT_W'(itoa_pkg::NIL_LEN - 1));

  assign res_o       = res_q;
  assign res_valid_o = valid_q;

endmodule

@@ hdl/integer_to_ascii_formatter.sv @@
// Top level of the integer-to-ASCII formatter: controller, datapath and checks.
// Decimal requests first run 32 double-dabble steps, one input bit per cycle, then a sizing
// step; hex and pointer requests go straight to sizing, then to character emission.
// busy stays high until the last beat is issued; results cannot be stalled.
// Asynchronous active-low reset returns the controller to idle and clears the result strobe.
module integer_to_ascii_formatter #(
  parameter int unsigned POINTER_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  itoa_pkg::req_t req_i,
  output logic           busy,
  output itoa_pkg::res_t res_o,
  output logic           res_valid_o
);

  itoa_pkg::ctrl_t cmd;
  itoa_pkg::stat_t stat;

  itoa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .fmt_i  (itoa_pkg::fmt_e'(req_i.req_type)),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  itoa_dp #(
    .POINTER_BITS (POINTER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_char |=> !res_valid_o)
    else $error("beat directly after last character");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_char |=> res_valid_o)
    else $error("gap inside a character string");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_char |=>
      res_o.char_count == $past(res_o.char_count) + itoa_pkg::CNT_W'(1))
    else $error("character count did not advance by one");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

endmodule
